// File: design/fcvd_pkg.sv
package fcvd_pkg;

  // Input word
  typedef struct packed {
    logic        command;
    logic [7:0]  layer;
    logic [63:0] stamp_us;
  } in_t;

  // Result word
  typedef struct packed {
    logic        layer_ok;
    logic        status_flip;
    logic        is_video;
    logic [6:0]  confidence;
    logic [31:0] frames_seen;
    logic [31:0] mean_interval;
    logic [47:0] interval_variance;
  } out_t;

  // Queued job between front and back
  typedef struct packed {
    logic        command;
    logic        layer_ok;
    logic [7:0]  layer;
    logic [63:0] stamp_us;
  } job_t;

  // One layer table entry
  typedef struct packed {
    logic [63:0] last_stamp;
    logic [31:0] frame_total;
    logic [31:0] avg_gap;
    logic [47:0] gap_variance;
    logic        video_flag;
    logic [6:0]  confidence_level;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Configuration registers
  typedef struct packed {
    logic [15:0] min_frames;
    logic [31:0] low_gap;
    logic [31:0] high_gap;
    logic [47:0] variance_limit;
  } cfg_t;

  // Divider request
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [47:0] den;
  } div_req_t;

  // Register indexes
  localparam logic [1:0] REG_MIN_FRAMES     = 2'd0;
  localparam logic [1:0] REG_LOW_GAP        = 2'd1;
  localparam logic [1:0] REG_HIGH_GAP       = 2'd2;
  localparam logic [1:0] REG_VARIANCE_LIMIT = 2'd3;

  // Reset values of the registers
  localparam logic [15:0] RST_MIN_FRAMES     = 16'd10;
  localparam logic [31:0] RST_LOW_GAP        = 32'd1048576;
  localparam logic [31:0] RST_HIGH_GAP       = 32'd6553600;
  localparam logic [47:0] RST_VARIANCE_LIMIT = 48'd1638400;

  // Arithmetic constants
  localparam logic [63:0] STAMP_SPAN   = 64'd65536000;
  // us to ms Q16.16 is x * 8192 / 125: split x by 125, then scale the remainder
  localparam logic [25:0] GAP_DIV      = 26'd125;
  localparam logic [26:0] GAP_RCP      = 27'd68719477;
  localparam logic [20:0] FRAC_RCP     = 21'd1073742;
  localparam logic [22:0] FPART_MAX    = 23'd7864320;
  localparam logic [63:0] FRAME_WEIGHT = 64'd60;
  localparam logic [21:0] VAR_WEIGHT   = 22'd40;
  localparam logic [6:0]  CONF_MAX     = 7'd100;
  localparam logic [6:0]  CONF_STEP    = 7'd10;
  localparam logic [6:0]  CONF_DROP    = 7'd5;

endpackage

// File: design/fcvd_ram.sv
module fcvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/fcvd_div.sv
module fcvd_div
  import fcvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        done,
  output logic [63:0] quo
);

  logic [6:0]  cnt_r;
  logic        done_r;
  logic [63:0] quo_r;
  logic [47:0] rem_r;
  logic [47:0] den_r;
  logic [48:0] shift;
  logic [48:0] sub;
  logic        take;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shift = {rem_r, quo_r[63]};
    sub   = shift - {1'b0, den_r};
    take  = shift >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      quo_r  <= req.num;
      den_r  <= req.den;
      rem_r  <= '0;
      cnt_r  <= 7'd64;
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      rem_r  <= take ? sub[47:0] : shift[47:0];
      quo_r  <= {quo_r[62:0], take};
      cnt_r  <= cnt_r - 7'd1;
      done_r <= (cnt_r == 7'd1);
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: design/fcvd_front.sv
module fcvd_front
  import fcvd_pkg::*;
#(
  parameter int LAYERS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic job_valid,
  output job_t job,
  input  logic job_pop
);

  job_t       q_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  logic       push;
  job_t       job_in;

  // Classify the incoming word
  always_comb begin
    job_in.command  = in_data.command;
    job_in.layer_ok = ({1'b0, in_data.layer} < 9'(LAYERS));
    job_in.layer    = in_data.layer;
    job_in.stamp_us = in_data.stamp_us;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_r];

  // Hold classified words until the back end takes them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_r[wr_r] <= job_in;
        wr_r      <= ~wr_r;
      end
      if (job_pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(job_pop);
    end
  end

endmodule

// File: design/fcvd_back.sv
module fcvd_back
  import fcvd_pkg::*;
#(
  parameter int LAYERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_pop,
  output div_req_t    div_req,
  input  logic        div_done,
  input  logic [63:0] div_quo,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data
);

  localparam int IDX_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_LOAD, ST_EVAL, ST_GAP_Q, ST_GAP_R, ST_GAP_F, ST_GAP_CHK,
    ST_MEAN_WAIT, ST_D2, ST_MUL, ST_VAR_GO, ST_VAR_WAIT, ST_DET, ST_FP_WAIT, ST_VP_GO,
    ST_VP_WAIT, ST_CONF, ST_APPLY, ST_OUT, ST_WRITE
  } state_t;

  state_t          state_r;
  state_t          prev_state_r;
  job_t            job_r;
  entry_t          ent_r;
  logic            changed_r;
  logic [LAYERS-1:0] valid_r;
  logic            out_valid_r;
  out_t            out_data_r;
  logic [63:0]     div_num_r;
  logic [47:0]     div_den_r;
  logic [25:0]     diff_r;
  logic [41:0]     mx_r;
  logic [18:0]     gap_q_r;
  logic [6:0]      gap_rem_r;
  logic [31:0]     gap_r;
  logic [31:0]     n_r;
  logic            ge_r;
  logic [31:0]     d1_r;
  logic [31:0]     d2_r;
  logic [47:0]     prod_r;
  logic [22:0]     fpart_r;
  logic [21:0]     vpart_r;
  logic [6:0]      conf_r;

  logic [IDX_W-1:0] idx;
  logic [ENTRY_W-1:0] ram_rdata;
  logic            slot_free;
  logic            ram_we;
  logic            div_start;
  logic [63:0]     diff;
  logic [31:0]     n_inc;
  logic [41:0]     scaled;
  logic            gap_ge;
  logic [23:0]     sum;
  logic [6:0]      dec;
  logic [6:0]      conf_delta;

  assign idx       = job_r.layer[IDX_W-1:0];
  assign slot_free = !out_valid_r || out_ready;
  assign ram_we    = (state_r == ST_WRITE) && slot_free && job_r.layer_ok;
  assign job_pop   = (state_r == ST_IDLE) && job_valid;

  // Kick the divider on the first cycle of each wait state
  assign div_start = (state_r != prev_state_r) &&
                     (state_r == ST_MEAN_WAIT || state_r == ST_VAR_WAIT ||
                      state_r == ST_FP_WAIT || state_r == ST_VP_WAIT);

  fcvd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(LAYERS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(ent_r),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // Working arithmetic on the entry copy
  always_comb begin
    diff   = job_r.stamp_us - ent_r.last_stamp;
    n_inc  = (ent_r.frame_total != '1) ? ent_r.frame_total + 32'd1 : ent_r.frame_total;
    scaled = {diff_r, 16'd0};
    gap_ge = (gap_r >= ent_r.avg_gap);
    sum    = 24'(fpart_r) + 24'(vpart_r);
    dec    = (ent_r.confidence_level > CONF_DROP) ? ent_r.confidence_level - CONF_DROP
                                                  : 7'd0;
    conf_delta = (conf_r >= ent_r.confidence_level) ? conf_r - ent_r.confidence_level
                                                    : ent_r.confidence_level - conf_r;
  end

  // Sequence one word through the table update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      prev_state_r <= ST_IDLE;
      out_valid_r  <= 1'b0;
      valid_r      <= '0;
    end else begin
      prev_state_r <= state_r;
      // Drop the result once taken, unless a new one is loaded in the same cycle
      if (out_valid_r && out_ready && state_r != ST_WRITE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            job_r     <= job;
            changed_r <= 1'b0;
            state_r   <= job.layer_ok ? ST_RD : ST_WRITE;
          end
        end
        ST_RD: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          ent_r   <= valid_r[idx] ? entry_t'(ram_rdata) : '0;
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          if (job_r.command) begin
            ent_r   <= '0;
            state_r <= ST_WRITE;
          end else if (ent_r.last_stamp == '0) begin
            ent_r.last_stamp  <= job_r.stamp_us;
            ent_r.frame_total <= 32'd1;
            state_r           <= ST_WRITE;
          end else begin
            ent_r.last_stamp <= job_r.stamp_us;
            mx_r             <= 42'(cfg.high_gap) * 42'd1000;
            diff_r           <= diff[25:0];
            if (diff < STAMP_SPAN) begin
              state_r <= ST_GAP_Q;
            end else begin
              state_r <= ST_OUT;
            end
          end
        end
        // Gap in ms Q16.16: quotient by 125 through a reciprocal
        ST_GAP_Q: begin
          gap_q_r <= 19'((53'(diff_r) * 53'(GAP_RCP)) >> 33);
          state_r <= ST_GAP_R;
        end
        ST_GAP_R: begin
          gap_rem_r <= 7'(diff_r - 26'(gap_q_r) * GAP_DIV);
          state_r   <= ST_GAP_F;
        end
        ST_GAP_F: begin
          gap_r   <= {gap_q_r, 13'd0} + 32'((28'(gap_rem_r) * 28'(FRAC_RCP)) >> 14);
          state_r <= ST_GAP_CHK;
        end
        ST_GAP_CHK: begin
          if (gap_r >= cfg.low_gap && scaled <= mx_r) begin
            ent_r.frame_total <= n_inc;
            n_r               <= n_inc;
            ge_r              <= gap_ge;
            d1_r              <= gap_ge ? gap_r - ent_r.avg_gap : ent_r.avg_gap - gap_r;
            div_num_r         <= gap_ge ? 64'(gap_r - ent_r.avg_gap)
                                        : 64'(ent_r.avg_gap - gap_r) + 64'(n_inc) - 64'd1;
            div_den_r         <= 48'(n_inc);
            state_r           <= ST_MEAN_WAIT;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_MEAN_WAIT: begin
          if (div_done) begin
            ent_r.avg_gap <= ge_r ? ent_r.avg_gap + div_quo[31:0]
                                  : ent_r.avg_gap - div_quo[31:0];
            state_r       <= ST_D2;
          end
        end
        ST_D2: begin
          d2_r    <= gap_ge ? gap_r - ent_r.avg_gap : ent_r.avg_gap - gap_r;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r  <= 48'((64'(d1_r) * 64'(d2_r)) >> 16);
          state_r <= ST_VAR_GO;
        end
        ST_VAR_GO: begin
          ge_r      <= (prod_r >= ent_r.gap_variance);
          div_num_r <= (prod_r >= ent_r.gap_variance)
                       ? 64'(prod_r - ent_r.gap_variance)
                       : 64'(ent_r.gap_variance - prod_r) + 64'(n_r) - 64'd1;
          div_den_r <= 48'(n_r);
          state_r   <= ST_VAR_WAIT;
        end
        ST_VAR_WAIT: begin
          if (div_done) begin
            ent_r.gap_variance <= ge_r ? ent_r.gap_variance + div_quo[47:0]
                                       : ent_r.gap_variance - div_quo[47:0];
            state_r            <= ST_DET;
          end
        end
        ST_DET: begin
          if (n_r >= 32'(cfg.min_frames) && ent_r.gap_variance <= cfg.variance_limit) begin
            if (cfg.min_frames == '0) begin
              fpart_r <= FPART_MAX;
              state_r <= ST_VP_GO;
            end else begin
              div_num_r <= (64'(n_r) * FRAME_WEIGHT) << 16;
              div_den_r <= 48'(cfg.min_frames);
              state_r   <= ST_FP_WAIT;
            end
          end else begin
            state_r <= ST_WRITE;
          end
        end
        ST_FP_WAIT: begin
          if (div_done) begin
            fpart_r <= (div_quo > 64'(FPART_MAX)) ? FPART_MAX : div_quo[22:0];
            state_r <= ST_VP_GO;
          end
        end
        ST_VP_GO: begin
          if (cfg.variance_limit != '0) begin
            div_num_r <= {cfg.variance_limit - ent_r.gap_variance, 16'd0};
            div_den_r <= cfg.variance_limit;
            state_r   <= ST_VP_WAIT;
          end else begin
            vpart_r <= '0;
            state_r <= ST_CONF;
          end
        end
        ST_VP_WAIT: begin
          if (div_done) begin
            vpart_r <= 22'(div_quo[16:0]) * VAR_WEIGHT;
            state_r <= ST_CONF;
          end
        end
        ST_CONF: begin
          conf_r  <= (sum[23:16] > 8'(CONF_MAX)) ? CONF_MAX : sum[22:16];
          state_r <= ST_APPLY;
        end
        ST_APPLY: begin
          if (!ent_r.video_flag) begin
            ent_r.video_flag       <= 1'b1;
            ent_r.confidence_level <= conf_r;
            changed_r              <= 1'b1;
          end else if (conf_delta > CONF_STEP) begin
            ent_r.confidence_level <= conf_r;
            changed_r              <= 1'b1;
          end
          state_r <= ST_WRITE;
        end
        ST_OUT: begin
          // Gap outside the window: drop confidence or restart the statistics
          if (ent_r.video_flag) begin
            ent_r.confidence_level <= dec;
            if (dec == '0) begin
              ent_r.video_flag <= 1'b0;
              changed_r        <= 1'b1;
            end
          end else begin
            ent_r.frame_total  <= 32'd1;
            ent_r.avg_gap      <= '0;
            ent_r.gap_variance <= '0;
          end
          state_r <= ST_WRITE;
        end
        ST_WRITE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            if (job_r.layer_ok) begin
              valid_r[idx] <= 1'b1;
              out_data_r   <= '{layer_ok:          1'b1,
                                status_flip:       changed_r,
                                is_video:          ent_r.video_flag,
                                confidence:        ent_r.confidence_level,
                                frames_seen:       ent_r.frame_total,
                                mean_interval:     ent_r.avg_gap,
                                interval_variance: ent_r.gap_variance};
            end else begin
              out_data_r <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign div_req.start = div_start;
  assign div_req.num   = div_num_r;
  assign div_req.den   = div_den_r;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

// File: design/frame_cadence_video_detector.sv
// Sequence: an ignored layer goes straight to the result; a layer clear or first frame only
//   passes the table read and evaluation; a gap outside the window skips the divisions; a
//   frame in the window runs two to four 64-step divisions in the shared bit-serial divider.
// Flow: one word at a time in the back end, held by any output stall; a two-word queue in
//   front takes new words meanwhile.
// Reset: synchronous active-low rst_n restores register defaults and clears all layer
//   entries at once through per-entry valid bits; no clearing pass.
module frame_cadence_video_detector
  import fcvd_pkg::*;
#(
  parameter int LAYERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);

  cfg_t        cfg_r;
  logic        job_valid;
  job_t        job;
  logic        job_pop;
  div_req_t    div_req;
  logic        div_done;
  logic [63:0] div_quo;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_frames     <= RST_MIN_FRAMES;
      cfg_r.low_gap        <= RST_LOW_GAP;
      cfg_r.high_gap       <= RST_HIGH_GAP;
      cfg_r.variance_limit <= RST_VARIANCE_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_FRAMES:     cfg_r.min_frames     <= cfg_wdata[15:0];
        REG_LOW_GAP:        cfg_r.low_gap        <= cfg_wdata[31:0];
        REG_HIGH_GAP:       cfg_r.high_gap       <= cfg_wdata[31:0];
        REG_VARIANCE_LIMIT: cfg_r.variance_limit <= cfg_wdata;
        default:            cfg_r <= cfg_r;
      endcase
    end
  end

  fcvd_front #(
    .LAYERS(LAYERS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .job_valid(job_valid),
    .job      (job),
    .job_pop  (job_pop)
  );

  fcvd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  fcvd_back #(
    .LAYERS(LAYERS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .job_valid(job_valid),
    .job      (job),
    .job_pop  (job_pop),
    .div_req  (div_req),
    .div_done (div_done),
    .div_quo  (div_quo),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  // An ignored layer reports an all-zero word
  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.layer_ok) |->
      (!out_data.status_flip && !out_data.is_video && out_data.confidence == '0 &&
       out_data.frames_seen == '0 && out_data.mean_interval == '0 &&
       out_data.interval_variance == '0))
    else $error("ignored layer gave non-zero result");

  // Confidence stays in percent
  a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.confidence <= CONF_MAX))
    else $error("confidence above 100");

  // A layer flagged as video never carries zero confidence
  a_video_conf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_video) |-> (out_data.confidence != '0))
    else $error("video flag with zero confidence");
`endif

endmodule
